FILE: hdl/kthrf_pkg.sv
// ----------------------------------------------------------------------------
// kthrf_pkg
// Shared constants and divider request/response types for the kth reduced
// fraction finder.
// ----------------------------------------------------------------------------
package kthrf_pkg;

    // Largest denominator covered by the totient table
    localparam int MAX_DEN = 4096;
    localparam int DEPTH   = MAX_DEN + 1;
    // Width of table entries, denominators and gcd operands
    localparam int DW      = $clog2(MAX_DEN + 1);
    // Divider iteration counter width
    localparam int CW      = $clog2(DW + 1);

    // Fixed port widths
    localparam int IDX_W   = 32;
    localparam int NUM_W   = 12;
    localparam int DEN_W   = 13;

    typedef struct packed {
        logic          start;
        logic [DW-1:0] dividend;
        logic [DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic          busy;
        logic          done;
        logic [DW-1:0] quot;
        logic [DW-1:0] rem;
    } t_div_rsp;

endpackage

FILE: hdl/kth_reduced_fraction_finder_unit.sv
// ----------------------------------------------------------------------------
// kth_reduced_fraction_finder_unit
// Returns the n-th reduced fraction in [0,1], ordered by denominator then
// numerator, from a totient table that a sieve fills after reset.
// ----------------------------------------------------------------------------
// Reset: synchronous, active low. The table is then written with phi[a] = a for every
//   index and sieved: each prime i updates phi[j] for every multiple j of i through the
//   shared divider. No request is taken until the sieve is done.
// Search: index 0 or 1 goes straight to the result. Otherwise phi[d] is read for each
//   denominator walked, then each candidate numerator is tested by Euclid's gcd on the divider.
// Throughput: one request at a time; the next is taken once the result is registered.
module kth_reduced_fraction_finder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [kthrf_pkg::IDX_W-1:0]   i_index,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [kthrf_pkg::NUM_W-1:0]   o_numerator,
    output logic [kthrf_pkg::DEN_W-1:0]   o_denominator,
    output logic                          o_out_of_range
);
    import kthrf_pkg::*;

    typedef enum logic [12:0] {
        S_INIT   = 13'b0000000000001,  // write phi[a] = a
        S_SV_RD  = 13'b0000000000010,  // read phi[i]
        S_SV_CHK = 13'b0000000000100,  // phi[i] == i -> i is prime
        S_J_RD   = 13'b0000000001000,  // read phi[j], j a multiple of i
        S_J_DIV  = 13'b0000000010000,  // start phi[j] / i
        S_J_WAIT = 13'b0000000100000,  // write phi[j] - phi[j]/i
        S_IDLE   = 13'b0000001000000,
        S_W_RD   = 13'b0000010000000,  // read phi[d]
        S_W_CHK  = 13'b0000100000000,  // subtract or stop at d
        S_K_NEXT = 13'b0001000000000,  // next candidate numerator
        S_G_TEST = 13'b0010000000000,  // gcd step or gcd finished
        S_G_WAIT = 13'b0100000000000,  // wait for x % y
        S_DONE   = 13'b1000000000000   // hand result to output register
    } t_state;

    t_state           r_state, n_state;
    logic             r_table_ready, n_table_ready;
    logic [DW-1:0]    r_a, n_a;        // init address, then denominator
    logic [DW-1:0]    r_i, n_i;        // sieve index
    logic [DW:0]      r_j, n_j;        // sieve multiple, may run past the table
    logic [DW-1:0]    r_phi, n_phi;    // saved phi[j]
    logic [IDX_W-1:0] r_rem, n_rem;    // remaining position count
    logic [DW-1:0]    r_k, n_k;        // candidate numerator
    logic [DW-1:0]    r_hits, n_hits;  // coprime numerators found
    logic [DW-1:0]    r_x, n_x;        // gcd operands
    logic [DW-1:0]    r_y, n_y;
    logic             r_perr, n_perr;  // pending out-of-range flag

    logic             r_ovalid, n_ovalid;
    logic [NUM_W-1:0] r_onum, n_onum;
    logic [DEN_W-1:0] r_oden, n_oden;
    logic             r_oerr, n_oerr;

    // totient table
    logic [DW-1:0]    r_mem [DEPTH];
    logic [DW-1:0]    r_rd;
    logic             mem_we;
    logic [DW-1:0]    mem_wa, mem_wd, mem_ra;

    t_div_req         div_req;
    t_div_rsp         div_rsp;

    logic [IDX_W-1:0] rd_ext;
    logic [DW:0]      j_step;
    logic             accept;

    assign rd_ext = IDX_W'(r_rd);
    assign j_step = r_j + {1'b0, r_i};
    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    kthrf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Shared divider: exact phi[j]/i in the sieve, x % y in the gcd
    always_comb begin
        div_req.start    = (r_state == S_J_DIV) || (r_state == S_G_TEST && r_y != '0);
        div_req.dividend = (r_state == S_J_DIV) ? r_rd : r_x;
        div_req.divisor  = (r_state == S_J_DIV) ? r_i  : r_y;
    end

    always_comb begin
        mem_ra = r_a;
        case (r_state)
            S_SV_RD: mem_ra = r_i;
            S_J_RD:  mem_ra = r_j[DW-1:0];
            default: mem_ra = r_a;
        endcase
    end

    always_comb begin
        n_state       = r_state;
        n_table_ready = r_table_ready;
        n_a           = r_a;
        n_i           = r_i;
        n_j           = r_j;
        n_phi         = r_phi;
        n_rem         = r_rem;
        n_k           = r_k;
        n_hits        = r_hits;
        n_x           = r_x;
        n_y           = r_y;
        n_perr        = r_perr;
        n_ovalid      = r_ovalid && !i_ready;
        n_onum        = r_onum;
        n_oden        = r_oden;
        n_oerr        = r_oerr;
        mem_we        = 1'b0;
        mem_wa        = r_a;
        mem_wd        = r_a;

        case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                if (r_a == DW'(MAX_DEN)) begin
                    n_i     = DW'(2);
                    n_state = S_SV_RD;
                end else begin
                    n_a = r_a + DW'(1);
                end
            end
            S_SV_RD: begin
                n_state = S_SV_CHK;
            end
            S_SV_CHK: begin
                if (r_rd == r_i) begin
                    n_j     = {1'b0, r_i};
                    n_state = S_J_RD;
                end else if (r_i == DW'(MAX_DEN)) begin
                    n_table_ready = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    n_i     = r_i + DW'(1);
                    n_state = S_SV_RD;
                end
            end
            S_J_RD: begin
                n_state = S_J_DIV;
            end
            S_J_DIV: begin
                n_phi   = r_rd;
                n_state = S_J_WAIT;
            end
            S_J_WAIT: begin
                if (div_rsp.done) begin
                    mem_we = 1'b1;
                    mem_wa = r_j[DW-1:0];
                    mem_wd = r_phi - div_rsp.quot;
                    n_j    = j_step;
                    if (j_step <= (DW+1)'(MAX_DEN)) begin
                        n_state = S_J_RD;
                    end else if (r_i == DW'(MAX_DEN)) begin
                        n_table_ready = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        n_i     = r_i + DW'(1);
                        n_state = S_SV_RD;
                    end
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_k    = '0;
                    n_perr = 1'b0;
                    if (i_index == '0) begin
                        // position zero does not exist
                        n_a     = '0;
                        n_perr  = 1'b1;
                        n_state = S_DONE;
                    end else if (i_index == IDX_W'(1)) begin
                        // first fraction is 0/1
                        n_a     = DW'(1);
                        n_state = S_DONE;
                    end else begin
                        n_rem   = i_index - IDX_W'(1);
                        n_a     = DW'(1);
                        n_state = S_W_RD;
                    end
                end
            end
            S_W_RD: begin
                n_state = S_W_CHK;
            end
            S_W_CHK: begin
                if (rd_ext >= r_rem) begin
                    n_k     = '0;
                    n_hits  = '0;
                    n_state = S_K_NEXT;
                end else begin
                    n_rem = r_rem - rd_ext;
                    if (r_a == DW'(MAX_DEN)) begin
                        // walked off the end of the table
                        n_a     = '0;
                        n_k     = '0;
                        n_perr  = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_a     = r_a + DW'(1);
                        n_state = S_W_RD;
                    end
                end
            end
            S_K_NEXT: begin
                n_k     = r_k + DW'(1);
                n_x     = r_a;
                n_y     = r_k + DW'(1);
                n_state = S_G_TEST;
            end
            S_G_TEST: begin
                if (r_y == '0) begin
                    if (r_x == DW'(1)) begin
                        n_hits = r_hits + DW'(1);
                        if (IDX_W'(r_hits) + IDX_W'(1) == r_rem) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_K_NEXT;
                        end
                    end else begin
                        n_state = S_K_NEXT;
                    end
                end else begin
                    n_state = S_G_WAIT;
                end
            end
            S_G_WAIT: begin
                if (div_rsp.done) begin
                    n_x     = r_y;
                    n_y     = div_rsp.rem;
                    n_state = S_G_TEST;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_onum   = NUM_W'(r_k);
                    n_oden   = DEN_W'(r_a);
                    n_oerr   = r_perr;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_table_ready <= 1'b0;
            r_a           <= '0;
            r_ovalid      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_table_ready <= n_table_ready;
            r_a           <= n_a;
            r_ovalid      <= n_ovalid;
        end
        r_i    <= n_i;
        r_j    <= n_j;
        r_phi  <= n_phi;
        r_rem  <= n_rem;
        r_k    <= n_k;
        r_hits <= n_hits;
        r_x    <= n_x;
        r_y    <= n_y;
        r_perr <= n_perr;
        r_onum <= n_onum;
        r_oden <= n_oden;
        r_oerr <= n_oerr;
    end

    assign o_ready        = (r_state == S_IDLE) && r_table_ready;
    assign o_valid        = r_ovalid;
    assign o_numerator    = r_onum;
    assign o_denominator  = r_oden;
    assign o_out_of_range = r_oerr;

`ifndef NO_ASSERTIONS
    a_table_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_table_ready |-> !mem_we)
        else $error("totient table written after the sieve finished");
    a_exact_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_J_WAIT && div_rsp.done) |-> div_rsp.rem == '0)
        else $error("sieve division left a remainder");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_of_range) |-> (o_numerator == '0 && o_denominator == '0))
        else $error("out-of-range result carries a fraction");
`endif

endmodule

FILE: hdl/kthrf_div.sv
// ----------------------------------------------------------------------------
// kthrf_div
// Restoring divider, one quotient bit per cycle. Shared by the totient
// sieve (exact quotient) and Euclid's gcd (remainder).
// ----------------------------------------------------------------------------
module kthrf_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kthrf_pkg::t_div_req i_req,
    output kthrf_pkg::t_div_rsp o_rsp
);
    import kthrf_pkg::*;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_part, n_part;
    logic [DW-1:0] r_quo, n_quo;
    logic [DW-1:0] r_dvs, n_dvs;

    logic [DW:0]   shifted;
    logic [DW+1:0] diff;
    logic          neg;

    assign shifted = {r_part, r_quo[DW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_dvs};
    assign neg     = diff[DW+1];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_part = r_part;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DW);
            n_part = '0;
            n_quo  = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            // keep the partial remainder when the trial subtract goes negative
            n_part = neg ? shifted[DW-1:0] : diff[DW-1:0];
            n_quo  = {r_quo[DW-2:0], ~neg};
            n_cnt  = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_part <= n_part;
        r_quo  <= n_quo;
        r_dvs  <= n_dvs;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_part;

`ifndef NO_ASSERTIONS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider restarted while busy");
    a_nonzero_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> i_req.divisor != '0)
        else $error("divide by zero requested");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held longer than one cycle");
`endif

endmodule
